### rtl/core/lsfd_pkg.sv
// shared types, constants and crc helper for the scan frame deframer
// no dependencies; imported by every module of the block

package lsfd_pkg;

   localparam int HEADER_ZEROS_DEF = 6;
   localparam int QUEUE_DEPTH_DEF  = 4;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 17;
   localparam int SIZE_W   = 17;
   localparam int ZRUN_W   = 3;
   localparam int AUX_W    = 16;
   localparam int INDEX_W  = 16;
   localparam int DIST_W   = 13;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;
   localparam int CRC_W    = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SIZE = 1'b1;
   localparam logic [SIZE_W-1:0]      MAX_SIZE_RESET = 17'd63974;

   localparam int MIN_SIZE = 22;

   // byte positions counted from the first crc byte
   localparam int POS_FIRST  = 2;
   localparam int POS_SIZE_HI = 2;
   localparam int POS_SIZE_LO = 3;
   localparam int POS_HEAD_END = 4;
   localparam int POS_TYPE0  = 16;
   localparam int POS_TYPE1  = 17;
   localparam int POS_DATA   = 20;

   localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
   localparam logic [BYTE_W-1:0] TYPE_IO   = 8'hAA;
   localparam logic [BYTE_W-1:0] TYPE_SCAN = 8'hBB;
   localparam logic [BYTE_W-1:0] TYPE_REFL = 8'hCC;

   typedef enum logic [STATUS_W-1:0] {
      ST_SCAN_OK   = 3'd0,
      ST_CRC_BAD   = 3'd1,
      ST_TYPE_MISM = 3'd2,
      ST_IO        = 3'd3,
      ST_REFLECTOR = 3'd4,
      ST_UNKNOWN   = 3'd5,
      ST_TOO_LARGE = 3'd6,
      ST_TOO_SMALL = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      OP_START  = 4'd0,
      OP_CRC    = 4'd1,
      OP_SIZE   = 4'd2,
      OP_TYPE0  = 4'd3,
      OP_TYPE1  = 4'd4,
      OP_LOW    = 4'd5,
      OP_DIST   = 4'd6,
      OP_SUM_LO = 4'd7,
      OP_SUM_HI = 4'd8,
      OP_REJECT = 4'd9
   } op_type;

   localparam logic RK_DIST   = 1'b0;
   localparam logic RK_STATUS = 1'b1;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
      logic [AUX_W-1:0]  aux;
   } entry_type;

   typedef struct packed {
      logic                kind;
      logic [INDEX_W-1:0]  index;
      logic [DIST_W-1:0]   range_cm;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } result_type;

   // crc-16, msb first, one byte
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
      end
      return c;
   endfunction

   // two zero bytes always open the checksum
   localparam logic [CRC_W-1:0] CRC_SEED = crc_byte(crc_byte(CRC_INIT, 8'h00), 8'h00);

endpackage

### rtl/core/laser_scan_frame_deframer_top.sv
// top level of the laser scan frame deframer: csr registers and wiring
// depends on lsfd_pkg, lsfd_front, lsfd_queue and lsfd_back

// One received byte per request, one request per clock while full is low.
// The front end hunts for the zero header, tracks the byte position and
// checks the size word; classified bytes go through a small queue to the
// back end, which runs the checksum one byte per cycle, checks the type and
// builds distance and end-of-packet status results into a single output
// register. A result is registered once its request has passed the queue;
// the sustained rate is one request per cycle while the output side keeps
// up, set by the one-byte crc step in the back end. While a result waits
// with pop low the back end stalls, and full rises once QUEUE_DEPTH
// classified bytes have piled up behind it; of the bytes seen in the hunt
// for the header only the last zero enters, as OP_START. Configuration
// writes are always taken (csr_ready stays high) and apply at once.

module laser_scan_frame_deframer_top
   import lsfd_pkg::*;
#(
   parameter int HEADER_ZEROS = HEADER_ZEROS_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   push,
   output logic                   full,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   // result side
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_result_kind,
   output logic [INDEX_W-1:0]     rsp_range_index,
   output logic [DIST_W-1:0]      rsp_range_cm,
   output logic [STATUS_W-1:0]    rsp_packet_status,
   output logic [COUNT_W-1:0]     rsp_range_count,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic              mirror_ff, mirror_in;
   logic [SIZE_W-1:0] max_size_ff, max_size_in;

   logic       take;
   logic       enq;
   entry_type  enq_entry;
   logic       head_valid;
   entry_type  head;
   logic       head_take;
   logic       q_full;
   logic       res_valid;
   result_type res;

   // a request is taken whenever the queue has room
   assign full      = q_full;
   assign take      = push && !q_full;
   assign csr_ready = 1'b1;

   // configuration write decode
   always_comb begin
      mirror_in   = mirror_ff;
      max_size_in = max_size_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIRROR:   mirror_in   = csr_data[0];
            CSR_MAX_SIZE: max_size_in = csr_data[SIZE_W-1:0];
            default:      mirror_in   = mirror_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff   <= 1'b0;
         max_size_ff <= MAX_SIZE_RESET;
      end else begin
         mirror_ff   <= mirror_in;
         max_size_ff <= max_size_in;
      end
   end

   // header hunt and byte classification
   lsfd_front #(
      .HEADER_ZEROS(HEADER_ZEROS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .max_size (max_size_ff),
      .enq      (enq),
      .entry    (enq_entry)
   );

   // decoupling queue, front never writes while full
   lsfd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (enq),
      .wr_entry (enq_entry),
      .rd_en    (head_take),
      .rd_valid (head_valid),
      .rd_entry (head),
      .q_full   (q_full)
   );

   // checksum, type check and result generation
   lsfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .mirror     (mirror_ff),
      .res_pop    (pop),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result ports straight from the output register
   assign empty             = !res_valid;
   assign rsp_result_kind   = res.kind;
   assign rsp_range_index   = res.index;
   assign rsp_range_cm      = res.range_cm;
   assign rsp_packet_status = res.status;
   assign rsp_range_count   = res.count;

endmodule

### rtl/core/lsfd_front.sv
// front end: header hunt, byte position tracking and size check
// depends on lsfd_pkg; emits classified entries toward the queue

module lsfd_front
   import lsfd_pkg::*;
#(
   parameter int HEADER_ZEROS = HEADER_ZEROS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [SIZE_W-1:0] max_size,
   output logic              enq,
   output entry_type         entry
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'b01,
      PH_BODY = 2'b10
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [ZRUN_W-1:0]  zrun_ff, zrun_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [BYTE_W-1:0]  hi_ff, hi_in;

   logic [ZRUN_W-1:0]  zrun_inc;
   logic [POS_W:0]     pos_wide, size_wide;
   logic               in_data;
   logic [15:0]        word;
   logic [SIZE_W-1:0]  size_new;
   logic [POS_W-1:0]   rel;

   assign zrun_inc  = zrun_ff + ZRUN_W'(1);
   assign pos_wide  = {1'b0, pos_ff};
   assign size_wide = {1'b0, size_ff};
   assign in_data   = (pos_wide + (POS_W+1)'(3)) <= size_wide;
   assign word      = {hi_ff, rx_byte};
   assign size_new  = {word, 1'b0};
   assign rel       = pos_ff - POS_W'(POS_DATA);

   always_comb begin
      phase_in = phase_ff;
      zrun_in  = zrun_ff;
      pos_in   = pos_ff;
      size_in  = size_ff;
      hi_in    = hi_ff;
      enq      = 1'b0;
      entry.op   = OP_CRC;
      entry.data = rx_byte;
      entry.aux  = '0;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte != '0) begin
                  zrun_in = '0;
               end else begin
                  zrun_in = zrun_inc;
                  if (zrun_inc >= ZRUN_W'(HEADER_ZEROS)) begin
                     phase_in = PH_BODY;
                     pos_in   = POS_W'(POS_FIRST);
                     enq      = 1'b1;
                     entry.op = OP_START;
                  end
               end
            end
            PH_BODY: begin
               pos_in = pos_ff + POS_W'(1);
               if (pos_ff == POS_W'(POS_SIZE_HI)) begin
                  hi_in = rx_byte;
                  enq   = 1'b1;
               end else if (pos_ff == POS_W'(POS_SIZE_LO)) begin
                  enq = 1'b1;
                  if (size_new > max_size) begin
                     entry.op  = OP_REJECT;
                     entry.aux = AUX_W'(ST_TOO_LARGE);
                     phase_in  = PH_HUNT;
                     zrun_in   = '0;
                  end else if (size_new < SIZE_W'(MIN_SIZE)) begin
                     entry.op  = OP_REJECT;
                     entry.aux = AUX_W'(ST_TOO_SMALL);
                     phase_in  = PH_HUNT;
                     zrun_in   = '0;
                  end else begin
                     entry.op  = OP_SIZE;
                     entry.aux = word - 16'(MIN_SIZE / 2);
                     size_in   = size_new;
                  end
               end else if (pos_ff == POS_W'(POS_TYPE0)) begin
                  enq      = 1'b1;
                  entry.op = OP_TYPE0;
               end else if (pos_ff == POS_W'(POS_TYPE1)) begin
                  enq      = 1'b1;
                  entry.op = OP_TYPE1;
               end else if (pos_ff >= POS_W'(POS_DATA) && in_data) begin
                  enq       = 1'b1;
                  entry.op  = pos_ff[0] ? OP_DIST : OP_LOW;
                  entry.aux = rel[POS_W-1:1];
               end else if (pos_wide + (POS_W+1)'(2) == size_wide) begin
                  enq      = 1'b1;
                  entry.op = OP_SUM_LO;
               end else if (pos_wide + (POS_W+1)'(1) == size_wide) begin
                  enq      = 1'b1;
                  entry.op = OP_SUM_HI;
                  phase_in = PH_HUNT;
                  zrun_in  = '0;
               end else if (in_data || pos_ff < POS_W'(POS_HEAD_END)) begin
                  enq = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               zrun_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         zrun_ff  <= '0;
         pos_ff   <= '0;
         size_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         zrun_ff  <= zrun_in;
         pos_ff   <= pos_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
   end

endmodule

### rtl/core/lsfd_queue.sv
// short entry queue that decouples the front end from the back end
// depends on lsfd_pkg for the entry type

module lsfd_queue
   import lsfd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_entry,
   input  logic      rd_en,
   output logic      rd_valid,
   output entry_type rd_entry,
   output logic      q_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign rd_valid = cnt_ff != '0;
   assign q_full   = cnt_ff == CNT_W'(DEPTH);
   assign rd_entry = slot_ff[rptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_entry;
      end
   end

endmodule

### rtl/core/lsfd_back.sv
// back end: crc accumulation, type check, distance and status results
// depends on lsfd_pkg; drains the entry queue into one result register

module lsfd_back
   import lsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head,
   output logic       head_take,
   input  logic       mirror,
   input  logic       res_pop,
   output logic       res_valid,
   output result_type res
);

   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic               match_ff, match_in;
   logic [BYTE_W-1:0]  hold_ff, hold_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff, valid_in;
   result_type         res_ff, res_in;

   logic [CRC_W-1:0]   crc_next;
   logic               scan;
   logic [COUNT_W-1:0] scan_count;
   logic [15:0]        word;
   status_type         end_status;

   assign head_take  = head_valid && (!valid_ff || res_pop);
   assign crc_next   = crc_byte(crc_ff, head.data);
   assign scan       = match_ff && (type_ff == TYPE_SCAN);
   assign scan_count = scan ? count_ff : '0;
   assign word       = {head.data, hold_ff};
   assign res_valid  = valid_ff;
   assign res        = res_ff;

   always_comb begin
      if (word != crc_ff) begin
         end_status = ST_CRC_BAD;
      end else if (!match_ff) begin
         end_status = ST_TYPE_MISM;
      end else if (type_ff == TYPE_IO) begin
         end_status = ST_IO;
      end else if (type_ff == TYPE_SCAN) begin
         end_status = ST_SCAN_OK;
      end else if (type_ff == TYPE_REFL) begin
         end_status = ST_REFLECTOR;
      end else begin
         end_status = ST_UNKNOWN;
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      type_in  = type_ff;
      match_in = match_ff;
      hold_in  = hold_ff;
      count_in = count_ff;
      valid_in = valid_ff && !res_pop;
      res_in   = res_ff;
      if (head_take) begin
         case (head.op)
            OP_START: begin
               crc_in   = CRC_SEED;
               type_in  = '0;
               match_in = 1'b0;
            end
            OP_CRC: begin
               crc_in = crc_next;
            end
            OP_SIZE: begin
               crc_in   = crc_next;
               count_in = head.aux;
            end
            OP_TYPE0: begin
               crc_in  = crc_next;
               type_in = head.data;
            end
            OP_TYPE1: begin
               crc_in   = crc_next;
               match_in = head.data == type_ff;
            end
            OP_LOW: begin
               crc_in  = crc_next;
               hold_in = head.data;
            end
            OP_DIST: begin
               crc_in = crc_next;
               if (scan) begin
                  valid_in        = 1'b1;
                  res_in.kind     = RK_DIST;
                  res_in.index    = mirror ? (count_ff - COUNT_W'(1) - head.aux) : head.aux;
                  res_in.range_cm = word[DIST_W-1:0];
                  res_in.status   = ST_SCAN_OK;
                  res_in.count    = count_ff;
               end
            end
            OP_SUM_LO: begin
               hold_in = head.data;
            end
            OP_SUM_HI: begin
               valid_in        = 1'b1;
               res_in.kind     = RK_STATUS;
               res_in.index    = '0;
               res_in.range_cm = '0;
               res_in.status   = end_status;
               res_in.count    = scan_count;
            end
            OP_REJECT: begin
               valid_in        = 1'b1;
               res_in.kind     = RK_STATUS;
               res_in.index    = '0;
               res_in.range_cm = '0;
               res_in.status   = head.aux[STATUS_W-1:0];
               res_in.count    = '0;
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         crc_ff   <= CRC_INIT;
         type_ff  <= '0;
         match_ff <= 1'b0;
         hold_ff  <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         crc_ff   <= crc_in;
         type_ff  <= type_in;
         match_ff <= match_in;
         hold_ff  <= hold_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

### rtl/core/lsfd_checker.sv
// port-level checks for the scan frame deframer top level
// bound to laser_scan_frame_deframer_top; depends on lsfd_pkg

module lsfd_checker
   import lsfd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                full,
   input logic                empty,
   input logic                pop,
   input logic                rsp_result_kind,
   input logic [INDEX_W-1:0]  rsp_range_index,
   input logic [DIST_W-1:0]   rsp_range_cm,
   input logic [STATUS_W-1:0] rsp_packet_status,
   input logic [COUNT_W-1:0]  rsp_range_count
);

   // reset leaves no result pending and room for requests
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("result pending or queue full after reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result_kind)
         && $stable(rsp_range_index) && $stable(rsp_range_cm)
         && $stable(rsp_packet_status) && $stable(rsp_range_count)))
      else $error("waiting result changed before pop");

   // a distance lies inside its scan and carries no status
   a_dist_in_scan: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_result_kind == RK_DIST) |->
         (rsp_range_index < rsp_range_count && rsp_packet_status == ST_SCAN_OK))
      else $error("distance index outside scan or status set");

   // a rejected size never reports distances
   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_result_kind == RK_STATUS &&
         (rsp_packet_status == ST_TOO_LARGE || rsp_packet_status == ST_TOO_SMALL)) |->
         (rsp_range_count == '0 && rsp_range_index == '0
          && rsp_range_cm == '0))
      else $error("size reject carries scan data");

endmodule

bind laser_scan_frame_deframer_top lsfd_checker u_lsfd_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_range_index   (rsp_range_index),
   .rsp_range_cm      (rsp_range_cm),
   .rsp_packet_status (rsp_packet_status),
   .rsp_range_count   (rsp_range_count)
);

### test/lsfd_frame_checker.sv
// crc helper for frame building plus the frame checker of the scan frame deframer
// depends on lsfd_pkg; watches the request, result and csr channels of the block

package lsfd_crc_pkg;
   import lsfd_pkg::*;

   // crc-16 ccitt, one byte shifted in msb first
   function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = acc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ data[i];
         c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction
endpackage

module lsfd_frame_checker
   import lsfd_pkg::*, lsfd_crc_pkg::*;
#(
   parameter int FRAME_ZEROS = HEADER_ZEROS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic                   empty,
   input  logic                   pop,
   input  logic                   rsp_result_kind,
   input  logic [INDEX_W-1:0]     rsp_range_index,
   input  logic [DIST_W-1:0]      rsp_range_cm,
   input  logic [STATUS_W-1:0]    rsp_packet_status,
   input  logic [COUNT_W-1:0]     rsp_range_count,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {SEEK_HEADER, IN_FRAME} frame_phase_type;

   frame_phase_type   frame_phase;
   logic [ZRUN_W-1:0] zero_cnt;
   logic [POS_W-1:0]  byte_pos;
   logic [SIZE_W-1:0] pkt_size;
   logic [CRC_W-1:0]  crc_acc;
   logic [BYTE_W-1:0] type_first;
   logic              types_equal;
   logic [BYTE_W-1:0] held_byte;
   logic              mirror_cfg;
   logic [SIZE_W-1:0] size_limit;
   result_type        expected_results[$];

   function automatic logic [COUNT_W-1:0] scan_ranges();
      if (types_equal && type_first == TYPE_SCAN) begin
         return COUNT_W'((int'(pkt_size) - MIN_SIZE) >> 1);
      end
      return '0;
   endfunction

   // advances the deframer state by one byte, returns 1 when a result is due
   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_type res);
      int                  cur;
      int                  sz;
      logic [COUNT_W-1:0]  ranges;
      logic [INDEX_W-1:0]  slot;
      status_type          st;
      res = '0;
      if (frame_phase == SEEK_HEADER) begin
         if (b != 8'h00) begin
            zero_cnt = '0;
            return 1'b0;
         end
         zero_cnt = zero_cnt + 3'd1;
         if (zero_cnt >= FRAME_ZEROS) begin
            frame_phase = IN_FRAME;
            byte_pos    = POS_W'(POS_FIRST);
            pkt_size    = '0;
            type_first  = '0;
            types_equal = 1'b0;
            crc_acc     = crc16_next(crc16_next(CRC_INIT, 8'h00), 8'h00);
         end
         return 1'b0;
      end

      cur      = int'(byte_pos);
      sz       = int'(pkt_size);
      byte_pos = byte_pos + 1'b1;
      if (cur < POS_HEAD_END || cur + 3 <= sz) crc_acc = crc16_next(crc_acc, b);

      if (cur == POS_SIZE_HI) begin
         held_byte = b;
         return 1'b0;
      end
      if (cur == POS_SIZE_LO) begin
         pkt_size = {held_byte, b, 1'b0};
         res.kind = RK_STATUS;
         if (pkt_size > size_limit) res.status = ST_TOO_LARGE;
         else if (pkt_size < MIN_SIZE) res.status = ST_TOO_SMALL;
         else return 1'b0;
         frame_phase = SEEK_HEADER;
         zero_cnt    = '0;
         return 1'b1;
      end
      if (cur == POS_TYPE0) type_first = b;
      else if (cur == POS_TYPE1) types_equal = (b == type_first);

      // range words, low byte first, sent as soon as complete
      if (cur >= POS_DATA && cur + 3 <= sz) begin
         if (!cur[0]) begin
            held_byte = b;
            return 1'b0;
         end
         if (!(types_equal && type_first == TYPE_SCAN)) return 1'b0;
         ranges       = scan_ranges();
         slot         = INDEX_W'((cur - POS_DATA) >> 1);
         res.kind     = RK_DIST;
         res.index    = mirror_cfg ? ranges - 1'b1 - slot : slot;
         res.range_cm = {b[DIST_W-BYTE_W-1:0], held_byte};
         res.count    = ranges;
         return 1'b1;
      end

      if (cur + 2 == sz) begin
         held_byte = b;
         return 1'b0;
      end
      if (cur + 1 == sz) begin
         if ({b, held_byte} != crc_acc) st = ST_CRC_BAD;
         else if (!types_equal) st = ST_TYPE_MISM;
         else begin
            case (type_first)
               TYPE_IO:   st = ST_IO;
               TYPE_SCAN: st = ST_SCAN_OK;
               TYPE_REFL: st = ST_REFLECTOR;
               default:   st = ST_UNKNOWN;
            endcase
         end
         res.kind    = RK_STATUS;
         res.status  = st;
         res.count   = scan_ranges();
         frame_phase = SEEK_HEADER;
         zero_cnt    = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t check failed: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type got;
      if (reset) begin
         frame_phase = SEEK_HEADER;
         zero_cnt    = '0;
         byte_pos    = '0;
         pkt_size    = '0;
         crc_acc     = CRC_INIT;
         type_first  = '0;
         types_equal = 1'b0;
         held_byte   = '0;
         mirror_cfg  = 1'b0;
         size_limit  = MAX_SIZE_RESET;
         expected_results.delete();
         backlog <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIRROR) mirror_cfg = csr_data[0];
            else if (csr_index == CSR_MAX_SIZE) size_limit = csr_data[SIZE_W-1:0];
         end
         if (push && !full) begin
            if (deframe_byte(req_rx_byte, want)) expected_results.push_back(want);
         end
         if (pop && !empty) begin
            got = {rsp_result_kind, rsp_range_index, rsp_range_cm, rsp_packet_status,
                   rsp_range_count};
            if (expected_results.size() == 0) begin
               report_mismatch("result with none pending, kind", got.kind, -1);
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch("result_kind", got.kind, want.kind);
               if (got.index !== want.index)
                  report_mismatch("range_index", got.index, want.index);
               if (got.range_cm !== want.range_cm)
                  report_mismatch("range_cm", got.range_cm, want.range_cm);
               if (got.status !== want.status)
                  report_mismatch("packet_status", got.status, want.status);
               if (got.count !== want.count)
                  report_mismatch("range_count", got.count, want.count);
            end
         end
         backlog <= expected_results.size();
      end
   end

endmodule

### test/tb_laser_scan_frame_deframer_top.sv
// testbench top for the laser scan frame deframer: clock, reset, byte stream and verdict
// depends on lsfd_pkg, lsfd_frame_checker.sv (lsfd_crc_pkg) and the deframer rtl

module tb_laser_scan_frame_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lsfd_pkg::*;
   import lsfd_crc_pkg::*;

   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES  = 12;    // settle margin, well above the result latency
   localparam int WATCHDOG_LIMIT = 3000;  // idle cycles, well above hold plus longest gap

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   push;
   logic                   full;
   logic [BYTE_W-1:0]      req_rx_byte;
   logic                   empty;
   logic                   pop;
   logic                   rsp_result_kind;
   logic [INDEX_W-1:0]     rsp_range_index;
   logic [DIST_W-1:0]      rsp_range_cm;
   logic [STATUS_W-1:0]    rsp_packet_status;
   logic [COUNT_W-1:0]     rsp_range_count;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int mismatches;
   int backlog;
   int quiet_cycles = 0;
   int bytes_sent;
   int frames_sent;
   int size_cap;        // max_size_bytes as last written, decides whether a body follows
   bit calm;            // no idling on either side while set
   bit hold_results;    // asks the receiver for one long hold-off

   laser_scan_frame_deframer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_range_index   (rsp_range_index),
      .rsp_range_cm      (rsp_range_cm),
      .rsp_packet_status (rsp_packet_status),
      .rsp_range_count   (rsp_range_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   lsfd_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_range_index   (rsp_range_index),
      .rsp_range_cm      (rsp_range_cm),
      .rsp_packet_status (rsp_packet_status),
      .rsp_range_count   (rsp_range_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .backlog           (backlog)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: ends the run when no request, result or csr write moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // result side: random pop gaps, plus one long hold-off on request
   initial begin : receiver
      int gap;
      pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         // hold pop low while the sender keeps offering, so full has to rise
         if (hold_results) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   // one request: optional idle gap, then hold push until full is low at an edge
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   // zero header, size word, then body and checksum if the size passes the limits
   task automatic send_frame(input logic [15:0] word, input logic [BYTE_W-1:0] t0,
                             input logic [BYTE_W-1:0] t1, input bit bad_sum);
      logic [BYTE_W-1:0] frame[$];
      logic [CRC_W-1:0]  acc;
      logic [BYTE_W-1:0] b;
      int                sz;
      int                roll;
      sz  = {word, 1'b0};
      acc = crc16_next(crc16_next(CRC_INIT, 8'h00), 8'h00);
      repeat (HEADER_ZEROS_DEF) frame.push_back(8'h00);
      frame.push_back(word[15:8]);
      frame.push_back(word[7:0]);
      acc = crc16_next(crc16_next(acc, word[15:8]), word[7:0]);
      if (sz >= MIN_SIZE && sz <= size_cap) begin
         // positions count from the first checksum byte, the size word sits at 2 and 3
         for (int r = POS_HEAD_END; r + 3 <= sz; r++) begin
            roll = $urandom_range(0, 9);
            if (r == POS_TYPE0) b = t0;
            else if (r == POS_TYPE1) b = t1;
            else if (roll == 0) b = 8'h00;
            else if (roll == 1) b = 8'hFF;
            else b = BYTE_W'($urandom);
            frame.push_back(b);
            acc = crc16_next(acc, b);
         end
         if (bad_sum) acc = acc ^ (16'd1 << $urandom_range(0, 15));
         frame.push_back(acc[7:0]);
         frame.push_back(acc[15:8]);
      end
      foreach (frame[k]) send_byte(frame[k]);
   endtask

   // line noise between frames: a broken header or a few random bytes,
   // always closed by a nonzero byte so the next header starts clean
   task automatic send_noise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         repeat ($urandom_range(1, HEADER_ZEROS_DEF - 1)) send_byte(8'h00);
         send_byte(BYTE_W'($urandom_range(1, 255)));
      end else if (roll < 45) begin
         repeat ($urandom_range(0, 5)) send_byte(BYTE_W'($urandom));
         send_byte(BYTE_W'($urandom_range(1, 255)));
      end
   endtask

   // well-formed frames with random content; the type case rotates so each
   // type and crc status shows when the limit passes bodies; sizes mostly small
   task automatic random_frame();
      logic [15:0]       word;
      logic [BYTE_W-1:0] t0;
      logic [BYTE_W-1:0] t1;
      bit                bad;
      int                roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) word = 16'($urandom_range(11, 30));
      else if (roll < 85) word = 16'($urandom_range(31, 260));
      else if (roll < 92 || size_cap >= 131070) word = 16'($urandom_range(0, 10));
      else word = 16'($urandom_range(size_cap / 2 + 1, 16'hFFFF));
      bad = ($urandom_range(0, 9) == 0);
      t0  = TYPE_SCAN;
      case (frames_sent % 8)
         3: t0 = TYPE_IO;
         4: t0 = TYPE_REFL;
         5: begin
            do t0 = BYTE_W'($urandom);
            while (t0 == TYPE_IO || t0 == TYPE_SCAN || t0 == TYPE_REFL);
         end
         6: if ($urandom_range(0, 1) == 0) t0 = BYTE_W'($urandom);
         7: bad = 1'b1;
         default: ;
      endcase
      // the mismatch case flips some bits of the second type byte
      t1 = (frames_sent % 8 == 6) ? t0 ^ BYTE_W'($urandom_range(1, 255)) : t0;
      frames_sent++;
      send_frame(word, t0, t1, bad);
   endtask

   task automatic run_frames(input int byte_target);
      while (bytes_sent < byte_target) begin
         send_noise();
         random_frame();
      end
   endtask

   // wait for every expected result, then let the pipeline drain
   task automatic settle();
      push <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers in one burst, valid stays high between the two writes
   task automatic set_config(input bit mirror, input int cap);
      settle();
      csr_valid <= 1'b1;
      csr_index <= CSR_MIRROR;
      csr_data  <= CSR_DATA_W'(mirror);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MAX_SIZE;
      csr_data  <= CSR_DATA_W'(cap);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_cap = cap;
   endtask

   initial begin : stimulus
      reset        <= 1'b1;
      push         <= 1'b0;
      req_rx_byte  <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_MIRROR;
      csr_data     <= '0;
      calm         = 1'b0;
      hold_results = 1'b0;
      size_cap     = MAX_SIZE_RESET;
      bytes_sent   = 0;
      frames_sent  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: size word of zero right after the header (long zero run),
      // all-ones size word over the limit, size just under the minimum
      send_frame(16'h0000, TYPE_SCAN, TYPE_SCAN, 1'b0);
      send_frame(16'hFFFF, TYPE_SCAN, TYPE_SCAN, 1'b0);
      send_frame(16'h000A, TYPE_SCAN, TYPE_SCAN, 1'b0);

      // reset settings: no mirroring, default size limit
      run_frames(280);

      // mirrored indexes, largest limit, and the long receiver hold-off
      set_config(1'b1, 131070);
      hold_results = 1'b1;
      run_frames(560);

      // limit at the minimum size: only the smallest frames get through; no idling
      set_config(1'b0, MIN_SIZE);
      calm = 1'b1;
      run_frames(720);
      calm = 1'b0;

      // limit of zero: every size word is rejected
      set_config(1'b1, 0);
      run_frames(820);

      // mid limit with mirroring
      set_config(1'b1, 100);
      run_frames(1050);

      // back to the reset values
      set_config(1'b0, MAX_SIZE_RESET);
      run_frames(1350);

      settle();
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
